// ----- sv/poisson_stencil_apply_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Poisson stencil block
// Shared forms for concurrent checks clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POISSON_STENCIL_APPLY_ASSERT_SVH
`define POISSON_STENCIL_APPLY_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PSA_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("poisson_stencil_apply: invariant violated");

// A condition that implies another in the same cycle.
`define PSA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("poisson_stencil_apply: implication violated");

`endif

// ----- sv/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// Poisson stencil package
// Shared constants, register indexes, status types and layout helpers.
// ----------------------------------------------------------------------------
package psa_pkg;

   // Sums, products and face quotients are clamped to plus or minus this bound.
   localparam logic [63:0] LIM = 64'h4000_0000_0000_0000;

   localparam int CSR_INDEX_W = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASS_FLOOR     = 4'd0,
      CSR_TIME_STEP      = 4'd1,
      CSR_INV_TIME_STEP  = 4'd2,
      CSR_INV_SPACING_SQ = 4'd3
   } csr_index_type;

   // Kind code bits: dirichlet is tested before neumann.
   localparam int KIND_DIRICHLET_BIT = 0;
   localparam int KIND_NEUMANN_BIT   = 1;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic signed [63:0] val;
      logic               sat;
   } sum_type;

   // One face: active, sign, numerator magnitude, mass.
   function automatic int face_width(input int dw);
      return 2 + 2 * dw;
   endfunction

   // Boundary flag, center value, inv_lambda_j and four faces.
   function automatic int item_width(input int dw);
      return 1 + 2 * dw + 4 * face_width(dw);
   endfunction

endpackage

// ----- sv/psa_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Carries one grid cell with its neighbors, face masses and cell kinds.
// ----------------------------------------------------------------------------
interface psa_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_center;
   logic signed [DATA_WIDTH-1:0] x_left;
   logic signed [DATA_WIDTH-1:0] x_right;
   logic signed [DATA_WIDTH-1:0] x_down;
   logic signed [DATA_WIDTH-1:0] x_up;
   logic [DATA_WIDTH-1:0]        mass_left;
   logic [DATA_WIDTH-1:0]        mass_right;
   logic [DATA_WIDTH-1:0]        mass_down;
   logic [DATA_WIDTH-1:0]        mass_up;
   logic [DATA_WIDTH-1:0]        inv_lambda_j;
   logic [1:0]                   center_kind;
   logic [7:0]                   neighbour_kinds;

   modport source (
      output valid, x_center, x_left, x_right, x_down, x_up,
             mass_left, mass_right, mass_down, mass_up, inv_lambda_j,
             center_kind, neighbour_kinds,
      input  ready
   );

   modport sink (
      input  valid, x_center, x_left, x_right, x_down, x_up,
             mass_left, mass_right, mass_down, mass_up, inv_lambda_j,
             center_kind, neighbour_kinds,
      output ready
   );
endinterface

// ----- sv/psa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Carries the operator value at one cell and its saturation flag.
// ----------------------------------------------------------------------------
interface psa_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         saturated;

   modport source (output valid, result_value, saturated, input ready);
   modport sink (input valid, result_value, saturated, output ready);
endinterface

// ----- sv/poisson_stencil_apply.sv -----
// ----------------------------------------------------------------------------
// Poisson stencil apply
// Mass-weighted five-point pressure Poisson operator on one grid cell.
// ----------------------------------------------------------------------------
// The block takes one cell per clock and returns one result per clock in the
// same order while the response channel is not stalled. The latency is set by
// the four face divisions, each a pipeline that resolves one quotient bit per
// stage; the wide products use two-stage multipliers. A two-entry queue sits
// between the classifier and the arithmetic pipeline, and the result register
// holds a finished value while a new cell is taken. Configuration must be
// written while no cell is in flight.

`include "poisson_stencil_apply_assert.svh"

module poisson_stencil_apply import psa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   psa_req_if.sink                req_chan,
   psa_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int PW = item_width(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] mass_floor_ff;
   logic [DATA_WIDTH-1:0] time_step_ff;
   logic [DATA_WIDTH-1:0] inv_time_step_ff;
   logic [DATA_WIDTH-1:0] inv_spacing_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_floor_ff     <= '0;
         time_step_ff      <= DATA_WIDTH'(655);
         inv_time_step_ff  <= DATA_WIDTH'(6553600);
         inv_spacing_sq_ff <= DATA_WIDTH'(65536);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MASS_FLOOR:     mass_floor_ff     <= csr_wr_data;
            CSR_TIME_STEP:      time_step_ff      <= csr_wr_data;
            CSR_INV_TIME_STEP:  inv_time_step_ff  <= csr_wr_data;
            CSR_INV_SPACING_SQ: inv_spacing_sq_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   logic          q_push;
   logic          q_pop;
   logic [PW-1:0] q_item_in;
   logic [PW-1:0] q_item_out;
   q_status_type  q_status;

   psa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .req_chan   (req_chan),
      .mass_floor (mass_floor_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (q_item_in)
   );

   psa_queue #(.ITEM_WIDTH(PW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .pop      (q_pop),
      .item_in  (q_item_in),
      .item_out (q_item_out),
      .status   (q_status)
   );

   psa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_item         (q_item_out),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .time_step      (time_step_ff),
      .inv_time_step  (inv_time_step_ff),
      .inv_spacing_sq (inv_spacing_sq_ff),
      .rsp_chan       (rsp_chan)
   );

   `PSA_ASSERT_IMPLY(a_pop_needs_item, q_pop, !q_status.empty)
   `PSA_ASSERT_IMPLY(a_push_needs_room, q_push, !q_status.full)
   `PSA_ASSERT_ALWAYS(a_queue_status, !(q_status.full && q_status.empty))

endmodule

// ----- sv/psa_front.sv -----
// ----------------------------------------------------------------------------
// Stencil front end
// Accepts a cell, classifies each face and forms the division numerators.
// ----------------------------------------------------------------------------
module psa_front import psa_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   psa_req_if.sink                           req_chan,
   input  logic [DATA_WIDTH-1:0]             mass_floor,
   input  q_status_type                      q_status,
   output logic                              q_push,
   output logic [item_width(DATA_WIDTH)-1:0] q_item
);

   localparam int W  = DATA_WIDTH;
   localparam int FW = face_width(DATA_WIDTH);

   logic signed [W-1:0] x_nbr [0:3];
   logic [W-1:0]        mass  [0:3];
   logic [FW-1:0]       face  [0:3];

   assign x_nbr[0] = req_chan.x_left;
   assign x_nbr[1] = req_chan.x_right;
   assign x_nbr[2] = req_chan.x_down;
   assign x_nbr[3] = req_chan.x_up;
   assign mass[0]  = req_chan.mass_left;
   assign mass[1]  = req_chan.mass_right;
   assign mass[2]  = req_chan.mass_down;
   assign mass[3]  = req_chan.mass_up;

   for (genvar i = 0; i < 4; i++) begin : g_face
      logic [1:0]        kind;
      logic              is_dir;
      logic              is_neu;
      logic              act;
      logic signed [W:0] num;
      logic [W:0]        num_mag;

      assign kind   = req_chan.neighbour_kinds[2*i +: 2];
      assign is_dir = kind[KIND_DIRICHLET_BIT];
      assign is_neu = kind[KIND_NEUMANN_BIT];
      // A neumann neighbor without the dirichlet bit contributes nothing, as does a face at or below threshold.
      assign act    = (mass[i] > mass_floor) && (is_dir || !is_neu);
      assign num    = is_dir ? (W+1)'(req_chan.x_center)
                             : (W+1)'(req_chan.x_center) - (W+1)'(x_nbr[i]);
      assign num_mag = num[W] ? -num : num;
      assign face[i] = {act, num[W], num_mag[W-1:0], mass[i]};
   end

   assign req_chan.ready = !q_status.full;
   assign q_push         = req_chan.valid && !q_status.full;
   assign q_item = {(req_chan.center_kind != 2'd0), req_chan.x_center,
                    req_chan.inv_lambda_j, face[3], face[2], face[1], face[0]};

endmodule

// ----- sv/psa_queue.sv -----
// ----------------------------------------------------------------------------
// Stencil item queue
// Two-entry FIFO that lets the front end and the arithmetic back end stall
// independently.
// ----------------------------------------------------------------------------
module psa_queue import psa_pkg::*; #(
   parameter int ITEM_WIDTH = 329
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  pop,
   input  logic [ITEM_WIDTH-1:0] item_in,
   output logic [ITEM_WIDTH-1:0] item_out,
   output q_status_type          status
);

   logic [ITEM_WIDTH-1:0] entry_ff [0:1];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= item_in;
   end

   assign item_out     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

// ----- sv/psa_mulq.sv -----
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage unsigned product shifted down by the fraction width and clamped.
// ----------------------------------------------------------------------------
module psa_mulq import psa_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] prod,
   output logic        sat
);

   logic [63:0]  pp_ff [0:3];
   logic [127:0] full_in;
   logic [127:0] shifted_in;
   logic [63:0]  prod_ff;
   logic         sat_ff;

   // First stage: four 32 by 32 partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff[0] <= 64'(a[31:0]) * 64'(b[31:0]);
         pp_ff[1] <= 64'(a[63:32]) * 64'(b[31:0]);
         pp_ff[2] <= 64'(a[31:0]) * 64'(b[63:32]);
         pp_ff[3] <= 64'(a[63:32]) * 64'(b[63:32]);
      end
   end

   assign full_in = {64'd0, pp_ff[0]} + {32'd0, pp_ff[1], 32'd0}
                  + {32'd0, pp_ff[2], 32'd0} + {pp_ff[3], 64'd0};
   assign shifted_in = full_in >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         if (shifted_in > {64'd0, LIM}) begin
            prod_ff <= LIM;
            sat_ff  <= 1'b1;
         end else begin
            prod_ff <= shifted_in[63:0];
            sat_ff  <= 1'b0;
         end
      end
   end

   assign prod = prod_ff;
   assign sat  = sat_ff;

endmodule

// ----- sv/psa_back.sv -----
// ----------------------------------------------------------------------------
// Stencil back end
// Pipelined face divisions, saturating sum, coefficient products and the
// result register.
// ----------------------------------------------------------------------------
module psa_back import psa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [item_width(DATA_WIDTH)-1:0] q_item,
   input  q_status_type                      q_status,
   output logic                              q_pop,
   input  logic [DATA_WIDTH-1:0]             time_step,
   input  logic [DATA_WIDTH-1:0]             inv_time_step,
   input  logic [DATA_WIDTH-1:0]             inv_spacing_sq,
   psa_rsp_if.source                         rsp_chan
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int QB = DATA_WIDTH + FRAC_BITS;
   localparam int FW = face_width(DATA_WIDTH);
   localparam int PW = item_width(DATA_WIDTH);
   localparam logic signed [63:0] HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] LO = -HI - 64'sd1;

   function automatic sum_type sat_add(input logic signed [63:0] x,
                                       input logic signed [63:0] y);
      logic signed [64:0] s;
      sum_type            r;
      s = $signed({x[63], x}) + $signed({y[63], y});
      if (s > $signed({1'b0, LIM})) begin
         r.val = $signed(LIM);
         r.sat = 1'b1;
      end else if (s < -$signed({1'b0, LIM})) begin
         r.val = -$signed(LIM);
         r.sat = 1'b1;
      end else begin
         r.val = s[63:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   logic en;
   logic rsp_valid_ff;

   // Each stage but the k multiplier steps when the result register is free.
   assign en    = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop = en && !q_status.empty;

   // ---------------- division stages ----------------
   logic [QB-1:0]       dvd_ff  [0:QB][0:3];
   logic [W-1:0]        rem_ff  [0:QB][0:3];
   logic [QB-1:0]       quo_ff  [0:QB][0:3];
   logic [W-1:0]        mass_ff [0:QB][0:3];
   logic                act_ff  [0:QB][0:3];
   logic                neg_ff  [0:QB][0:3];
   logic                vld_d_ff [0:QB];
   logic                bnd_d_ff [0:QB];
   logic signed [W-1:0] xc_d_ff  [0:QB];
   logic [W-1:0]        ilj_d_ff [0:QB];

   for (genvar i = 0; i < 4; i++) begin : g_load
      logic [FW-1:0] face;
      assign face = q_item[i*FW +: FW];
      always_ff @(posedge clock) begin
         if (en) begin
            act_ff[0][i]  <= face[FW-1];
            neg_ff[0][i]  <= face[FW-2];
            dvd_ff[0][i]  <= {face[2*W-1:W], {F{1'b0}}};
            mass_ff[0][i] <= face[W-1:0];
            rem_ff[0][i]  <= '0;
            quo_ff[0][i]  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bnd_d_ff[0] <= q_item[PW-1];
         xc_d_ff[0]  <= q_item[PW-2 -: W];
         ilj_d_ff[0] <= q_item[PW-2-W -: W];
      end
   end

   // One quotient bit per stage: restoring long division.
   for (genvar j = 0; j < QB; j++) begin : g_step
      for (genvar i = 0; i < 4; i++) begin : g_lane
         logic [W:0] trial;
         logic [W:0] diff;
         logic       ge;
         assign trial = {rem_ff[j][i], dvd_ff[j][i][QB-1]};
         assign diff  = trial - {1'b0, mass_ff[j][i]};
         assign ge    = trial >= {1'b0, mass_ff[j][i]};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1][i]  <= ge ? diff[W-1:0] : trial[W-1:0];
               quo_ff[j+1][i]  <= {quo_ff[j][i][QB-2:0], ge};
               dvd_ff[j+1][i]  <= {dvd_ff[j][i][QB-2:0], 1'b0};
               mass_ff[j+1][i] <= mass_ff[j][i];
               act_ff[j+1][i]  <= act_ff[j][i];
               neg_ff[j+1][i]  <= neg_ff[j][i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            bnd_d_ff[j+1] <= bnd_d_ff[j];
            xc_d_ff[j+1]  <= xc_d_ff[j];
            ilj_d_ff[j+1] <= ilj_d_ff[j];
         end
      end
   end

   // ---------------- face terms ----------------
   logic signed [63:0] term_in [0:3];
   logic [3:0]         face_sat;

   for (genvar i = 0; i < 4; i++) begin : g_term
      logic [127:0] q_wide;
      logic         q_big;
      logic [63:0]  q_mag;
      assign q_wide = {{(128-QB){1'b0}}, quo_ff[QB][i]};
      assign q_big  = q_wide > {64'd0, LIM};
      assign q_mag  = q_big ? LIM : q_wide[63:0];
      assign term_in[i] = !act_ff[QB][i] ? 64'sd0
                        : (neg_ff[QB][i] ? -$signed(q_mag) : $signed(q_mag));
      assign face_sat[i] = act_ff[QB][i] && q_big;
   end

   logic                vld_t_ff, bnd_t_ff, sat_t_ff;
   logic signed [W-1:0] xc_t_ff;
   logic signed [63:0]  t_ff [0:3];

   always_ff @(posedge clock) begin
      if (en) begin
         bnd_t_ff <= bnd_d_ff[QB];
         xc_t_ff  <= xc_d_ff[QB];
         sat_t_ff <= |face_sat;
         for (int i = 0; i < 4; i++) t_ff[i] <= term_in[i];
      end
   end

   // ---------------- coefficient products ----------------
   logic [63:0] k_prod, c_prod, xcc_prod, sk_prod;
   logic        k_sat, c_sat, xcc_sat, sk_sat;

   psa_mulq #(.FRAC_BITS(F)) u_mul_k (
      .clock (clock),
      .en    (1'b1),
      .a     (64'(time_step)),
      .b     (64'(inv_spacing_sq)),
      .prod  (k_prod),
      .sat   (k_sat)
   );

   psa_mulq #(.FRAC_BITS(F)) u_mul_c (
      .clock (clock),
      .en    (en),
      .a     (64'(inv_time_step)),
      .b     (64'(ilj_d_ff[QB])),
      .prod  (c_prod),
      .sat   (c_sat)
   );

   // ---------------- saturating sum ----------------
   logic                vld_s1_ff, bnd_s1_ff, sat_s1_ff;
   logic signed [W-1:0] xc_s1_ff;
   logic signed [63:0]  s1_ff, t2_s1_ff, t3_s1_ff;
   logic                vld_s2_ff, bnd_s2_ff, sat_s2_ff;
   logic signed [W-1:0] xc_s2_ff;
   logic signed [63:0]  s2_ff, t3_s2_ff;
   logic                vld_s3_ff, bnd_s3_ff, sat_s3_ff;
   logic signed [W-1:0] xc_s3_ff;
   logic signed [63:0]  s3_ff;
   sum_type             add1_in, add2_in, add3_in;
   logic signed [63:0]  xc_s1_wide;

   assign add1_in    = sat_add(t_ff[0], t_ff[1]);
   assign add2_in    = sat_add(s1_ff, t2_s1_ff);
   assign add3_in    = sat_add(s2_ff, t3_s2_ff);
   assign xc_s1_wide = 64'(xc_s1_ff);

   psa_mulq #(.FRAC_BITS(F)) u_mul_xc (
      .clock (clock),
      .en    (en),
      .a     (mag64(xc_s1_wide)),
      .b     (c_prod),
      .prod  (xcc_prod),
      .sat   (xcc_sat)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         bnd_s1_ff <= bnd_t_ff;
         xc_s1_ff  <= xc_t_ff;
         s1_ff     <= add1_in.val;
         t2_s1_ff  <= t_ff[2];
         t3_s1_ff  <= t_ff[3];
         sat_s1_ff <= sat_t_ff | add1_in.sat;

         bnd_s2_ff <= bnd_s1_ff;
         xc_s2_ff  <= xc_s1_ff;
         s2_ff     <= add2_in.val;
         t3_s2_ff  <= t3_s1_ff;
         sat_s2_ff <= sat_s1_ff | add2_in.sat | c_sat;

         bnd_s3_ff <= bnd_s2_ff;
         xc_s3_ff  <= xc_s2_ff;
         s3_ff     <= add3_in.val;
         sat_s3_ff <= sat_s2_ff | add3_in.sat;
      end
   end

   // ---------------- scaling ----------------
   psa_mulq #(.FRAC_BITS(F)) u_mul_s (
      .clock (clock),
      .en    (en),
      .a     (mag64(s3_ff)),
      .b     (k_prod),
      .prod  (sk_prod),
      .sat   (sk_sat)
   );

   logic               vld_p1_ff, bnd_p1_ff, sat_p1_ff, sneg_p1_ff;
   logic signed [63:0] xs_p1_ff;
   logic               vld_p2_ff, bnd_p2_ff, sat_p2_ff, sneg_p2_ff;
   logic signed [63:0] xs_p2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         bnd_p1_ff  <= bnd_s3_ff;
         sneg_p1_ff <= s3_ff < 0;
         xs_p1_ff   <= xc_s3_ff[W-1] ? -$signed(xcc_prod) : $signed(xcc_prod);
         sat_p1_ff  <= sat_s3_ff | xcc_sat | k_sat;

         bnd_p2_ff  <= bnd_p1_ff;
         sneg_p2_ff <= sneg_p1_ff;
         xs_p2_ff   <= xs_p1_ff;
         sat_p2_ff  <= sat_p1_ff;
      end
   end

   // ---------------- final sum, clip and result register ----------------
   logic signed [63:0] sk_signed;
   sum_type            fin_in;
   logic signed [W-1:0] result_in;
   logic               sat_in;
   logic signed [W-1:0] result_ff;
   logic               sat_ff;

   assign sk_signed = sneg_p2_ff ? -$signed(sk_prod) : $signed(sk_prod);
   assign fin_in    = sat_add(sk_signed, xs_p2_ff);

   always_comb begin
      if (bnd_p2_ff) begin
         result_in = '0;
         sat_in    = 1'b0;
      end else if (fin_in.val > HI) begin
         result_in = HI[W-1:0];
         sat_in    = 1'b1;
      end else if (fin_in.val < LO) begin
         result_in = LO[W-1:0];
         sat_in    = 1'b1;
      end else begin
         result_in = fin_in.val[W-1:0];
         sat_in    = sat_p2_ff | sk_sat | fin_in.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QB; j++) vld_d_ff[j] <= 1'b0;
         vld_t_ff     <= 1'b0;
         vld_s1_ff    <= 1'b0;
         vld_s2_ff    <= 1'b0;
         vld_s3_ff    <= 1'b0;
         vld_p1_ff    <= 1'b0;
         vld_p2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_d_ff[0] <= !q_status.empty;
         for (int j = 0; j < QB; j++) vld_d_ff[j+1] <= vld_d_ff[j];
         vld_t_ff     <= vld_d_ff[QB];
         vld_s1_ff    <= vld_t_ff;
         vld_s2_ff    <= vld_s1_ff;
         vld_s3_ff    <= vld_s2_ff;
         vld_p1_ff    <= vld_s3_ff;
         vld_p2_ff    <= vld_p1_ff;
         rsp_valid_ff <= vld_p2_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = result_ff;
   assign rsp_chan.saturated    = sat_ff;

endmodule
